// ===== src/xee_pkg.sv =====
// Shared types, character codes and helper functions of the entity escaper.
package xee_pkg;

    // Field widths
    localparam int CP_W    = 21;
    localparam int CH_W    = 7;
    localparam int DIGIT_W = 4;

    // Sequencer index and decimal converter sizes
    localparam int IDX_W      = 3;
    localparam int DEC_DIGITS = 7;
    localparam int DCNT_W     = 3;

    // Divide by ten: q = (v * DIV10_MUL) >> DIV10_SHIFT, exact for v below 2**22
    localparam int DIV10_MUL_W             = 22;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 22'd3355444;
    localparam int DIV10_SHIFT             = 25;
    localparam int DIV_PROD_W              = CP_W + DIV10_MUL_W;

    // ASCII characters written by the back end
    localparam logic [CH_W-1:0] CH_AMP   = 7'h26;
    localparam logic [CH_W-1:0] CH_HASH  = 7'h23;
    localparam logic [CH_W-1:0] CH_SEMI  = 7'h3B;
    localparam logic [CH_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CH_W-1:0] CH_THREE = 7'h33;
    localparam logic [CH_W-1:0] CH_EIGHT = 7'h38;

    // Code points examined by the front end
    localparam logic [CP_W-1:0] CP_AMP   = 21'd38;
    localparam logic [CP_W-1:0] CP_HASH  = 21'd35;
    localparam logic [CP_W-1:0] CP_SEMI  = 21'd59;
    localparam logic [CP_W-1:0] CP_ZERO  = 21'd48;
    localparam logic [CP_W-1:0] CP_NINE  = 21'd57;
    localparam logic [CP_W-1:0] CP_LT    = 21'd60;
    localparam logic [CP_W-1:0] CP_GT    = 21'd62;
    localparam logic [CP_W-1:0] CP_QUOT  = 21'd34;
    localparam logic [CP_W-1:0] CP_APOS  = 21'd39;
    localparam logic [CP_W-1:0] CP_SLASH = 21'd47;
    localparam logic [CP_W-1:0] CP_ASCII_LIMIT = 21'd128;

    // Leading text of a job
    typedef enum logic [1:0] {
        PRE_NONE,       // nothing
        PRE_AMP,        // "&#38;"
        PRE_AMPHASH,    // "&#38;#"
        PRE_HASH        // "&#"
    } pre_kind_t;

    // Trailing text of a job, after the held digits
    typedef enum logic [1:0] {
        TAIL_NONE,      // nothing
        TAIL_RAW,       // the code point as one ASCII character
        TAIL_SEMI,      // ";"
        TAIL_NUM        // "&#" decimal(code point) ";"
    } tail_kind_t;

    // Control part of one job passed from front end to back end
    typedef struct packed {
        logic                last;
        pre_kind_t           pre;
        tail_kind_t          tail;
        logic [CP_W-1:0]     code_point;
    } job_ctl_t;

    // Index of the final character of a leading text
    function automatic logic [IDX_W-1:0] prefix_last_idx(input pre_kind_t pre);
        logic [IDX_W-1:0] r;
        case (pre)
            PRE_AMP:     r = 3'd4;
            PRE_AMPHASH: r = 3'd5;
            PRE_HASH:    r = 3'd1;
            default:     r = 3'd0;
        endcase
        return r;
    endfunction

    // All leading texts share the spelling "&#38;#", cut at different lengths
    function automatic logic [CH_W-1:0] prefix_char(input logic [IDX_W-1:0] idx);
        logic [CH_W-1:0] r;
        case (idx)
            3'd0:    r = CH_AMP;
            3'd1:    r = CH_HASH;
            3'd2:    r = CH_THREE;
            3'd3:    r = CH_EIGHT;
            3'd4:    r = CH_SEMI;
            default: r = CH_HASH;
        endcase
        return r;
    endfunction

endpackage

// ===== src/xee_in_if.sv =====
// Input channel: one code point word per handshake.
interface xee_in_if import xee_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            is_last;

    modport source (output valid, output code_point, output is_last, input ready);
    modport sink   (input valid, input code_point, input is_last, output ready);
endinterface

// ===== src/xee_out_if.sv =====
// Output channel: one escaped ASCII character word per handshake.
interface xee_out_if import xee_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_char;
    logic            last_of_run;
    logic            end_of_text;

    modport source (output valid, output out_char, output last_of_run,
                    output end_of_text, input ready);
    modport sink   (input valid, input out_char, input last_of_run,
                    input end_of_text, output ready);
endinterface

// ===== src/xee_front.sv =====
// Front end: accepts code points, tracks entity state and classifies each word into a job.
module xee_front import xee_pkg::*; #(
    parameter int MAX_ENTITY_DIGITS = 4,
    parameter int CNT_W             = 3
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    xee_in_if.sink                               points,
    input  logic                                 q_full,
    output logic                                 push,
    output job_ctl_t                             job_ctl,
    output logic [CNT_W-1:0]                     job_n,
    output logic [MAX_ENTITY_DIGITS*DIGIT_W-1:0] job_held
);

    typedef enum logic [1:0] {
        M_PLAIN,
        M_AMP,
        M_NUM
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIGIT_W-1:0] held_reg  [MAX_ENTITY_DIGITS];
    logic [DIGIT_W-1:0] held_next [MAX_ENTITY_DIGITS];

    logic            accept;
    logic            make_job;
    logic            wr_digit;
    logic [CP_W-1:0] c;
    logic            is_digit;
    pre_kind_t       pre;
    tail_kind_t      tail;
    logic [CNT_W-1:0] n_out;

    // Tail for a character that ends up escaped or written as is
    function automatic tail_kind_t tail_of(input logic [CP_W-1:0] cp);
        logic special;
        special = (cp == CP_LT) || (cp == CP_GT) || (cp == CP_QUOT) ||
                  (cp == CP_APOS) || (cp == CP_SLASH) || (cp >= CP_ASCII_LIMIT);
        return special ? TAIL_NUM : TAIL_RAW;
    endfunction

    assign points.ready = !q_full;
    assign accept       = points.valid && points.ready;
    assign c            = points.code_point;
    assign is_digit     = (c >= CP_ZERO) && (c <= CP_NINE);

    // Classify the word against the entity state
    always_comb
    begin
        make_job  = 1'b0;
        pre       = PRE_NONE;
        tail      = TAIL_NONE;
        n_out     = '0;
        wr_digit  = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;

        case (mode_reg)
            M_AMP:
            begin
                if (c == CP_HASH)
                begin
                    mode_next = M_NUM;
                    cnt_next  = '0;
                    if (points.is_last)
                    begin
                        make_job = 1'b1;
                        pre      = PRE_AMPHASH;
                    end
                end
                else
                begin
                    make_job  = 1'b1;
                    pre       = PRE_AMP;
                    tail      = tail_of(c);
                    mode_next = M_PLAIN;
                end
            end
            M_NUM:
            begin
                if (is_digit && (cnt_reg < CNT_W'(MAX_ENTITY_DIGITS)))
                begin
                    wr_digit = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (points.is_last)
                    begin
                        make_job = 1'b1;
                        pre      = PRE_AMPHASH;
                        n_out    = cnt_reg + CNT_W'(1);
                    end
                end
                else if (c == CP_SEMI)
                begin
                    make_job  = 1'b1;
                    tail      = TAIL_SEMI;
                    mode_next = M_PLAIN;
                    if (cnt_reg == '0)
                    begin
                        pre = PRE_AMPHASH;
                    end
                    else
                    begin
                        pre   = PRE_HASH;
                        n_out = cnt_reg;
                    end
                end
                else
                begin
                    make_job  = 1'b1;
                    pre       = PRE_AMPHASH;
                    n_out     = cnt_reg;
                    tail      = tail_of(c);
                    mode_next = M_PLAIN;
                end
            end
            default:
            begin
                mode_next = M_PLAIN;
                if (c == CP_AMP)
                begin
                    if (points.is_last)
                    begin
                        make_job = 1'b1;
                        pre      = PRE_AMP;
                    end
                    else
                    begin
                        mode_next = M_AMP;
                    end
                end
                else
                begin
                    make_job = 1'b1;
                    tail     = tail_of(c);
                end
            end
        endcase

        // End of text drops any entity in progress
        if (points.is_last)
        begin
            mode_next = M_PLAIN;
            cnt_next  = '0;
        end

        // Insert the new digit at the next free slot
        for (int i = 0; i < MAX_ENTITY_DIGITS; i++)
        begin
            held_next[i] = (wr_digit && (cnt_reg == CNT_W'(i))) ? c[DIGIT_W-1:0]
                                                                 : held_reg[i];
        end
    end

    // Drive the job toward the queue
    always_comb
    begin
        push                   = accept && make_job;
        job_ctl.last           = points.is_last;
        job_ctl.pre            = pre;
        job_ctl.tail           = tail;
        job_ctl.code_point     = c;
        job_n                  = n_out;
        for (int i = 0; i < MAX_ENTITY_DIGITS; i++)
        begin
            job_held[i*DIGIT_W +: DIGIT_W] = held_next[i];
        end
    end

    // Hold entity state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_PLAIN;
            cnt_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold digits of the entity being checked
    always_ff @(posedge clk)
    begin
        if (accept && wr_digit)
        begin
            held_reg <= held_next;
        end
    end

endmodule

// ===== src/xee_fifo.sv =====
// Job queue between front end and back end.
module xee_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/xee_back.sv =====
// Back end: expands one job per run into characters, with a digit-per-cycle decimal converter.
module xee_back import xee_pkg::*; #(
    parameter int MAX_ENTITY_DIGITS = 4,
    parameter int CNT_W             = 3
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    output logic                                 pop,
    input  job_ctl_t                             job_ctl,
    input  logic [CNT_W-1:0]                     job_n,
    input  logic [MAX_ENTITY_DIGITS*DIGIT_W-1:0] job_held,
    xee_out_if.source                            chars
);

    localparam int HIDX_W     = (MAX_ENTITY_DIGITS > 1) ? $clog2(MAX_ENTITY_DIGITS) : 1;
    localparam int NUM_PHASES = 6;
    localparam int CMP_W      = IDX_W + 1;

    typedef enum logic [2:0] {
        PH_PRE,
        PH_HELD,
        PH_TPRE,
        PH_DEC,
        PH_RAW,
        PH_SEMI
    } phase_t;

    // Current job
    logic                  cur_valid_reg;
    job_ctl_t              ctl_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [DIGIT_W-1:0]    held_reg [MAX_ENTITY_DIGITS];
    logic [NUM_PHASES-1:0] mask_reg;
    phase_t                phase_reg;
    logic [IDX_W-1:0]      idx_reg;

    // Decimal converter
    logic                  conv_busy_reg;
    logic [DCNT_W-1:0]     dec_cnt_reg;
    logic [CP_W-1:0]       conv_val_reg;
    logic [DIGIT_W-1:0]    dec_stack_reg [DEC_DIGITS];
    logic [DIV_PROD_W-1:0] prod;
    logic [CP_W-1:0]       quot;
    logic [CP_W-1:0]       quot10;
    logic [DIGIT_W-1:0]    rem;

    // Output register
    logic                  out_valid_reg;
    logic [CH_W-1:0]       out_char_reg;
    logic                  out_lor_reg;
    logic                  out_eot_reg;

    logic                  ph_last;
    logic [CH_W-1:0]       ch;
    logic [3:0]            nxt;
    logic [3:0]            first;
    logic [NUM_PHASES-1:0] new_mask;
    logic                  job_end;
    logic                  char_ok;
    logic                  out_free;
    logic                  emit;
    logic                  load;
    logic                  conv_start;
    logic                  conv_pop;

    // Phases that a job passes through, in order
    function automatic logic [NUM_PHASES-1:0] mask_of(input pre_kind_t pre,
                                                       input tail_kind_t tail,
                                                       input logic has_held);
        logic [NUM_PHASES-1:0] m;
        m          = '0;
        m[PH_PRE]  = (pre != PRE_NONE);
        m[PH_HELD] = has_held;
        m[PH_TPRE] = (tail == TAIL_NUM);
        m[PH_DEC]  = (tail == TAIL_NUM);
        m[PH_RAW]  = (tail == TAIL_RAW);
        m[PH_SEMI] = (tail == TAIL_NUM) || (tail == TAIL_SEMI);
        return m;
    endfunction

    // First enabled phase at or after a start point: {found, phase}
    function automatic logic [3:0] find_phase(input logic [NUM_PHASES-1:0] m,
                                              input logic [2:0] from);
        logic       found;
        logic [2:0] sel;
        found = 1'b0;
        sel   = '0;
        for (int i = 0; i < NUM_PHASES; i++)
        begin
            if (!found && (3'(i) >= from) && m[i])
            begin
                found = 1'b1;
                sel   = 3'(i);
            end
        end
        return {found, sel};
    endfunction

    // Divide by ten with a reciprocal multiply
    always_comb
    begin
        prod   = {{DIV10_MUL_W{1'b0}}, conv_val_reg} * {{CP_W{1'b0}}, DIV10_MUL};
        quot   = CP_W'(prod[DIV_PROD_W-1:DIV10_SHIFT]);
        quot10 = (quot << 3) + (quot << 1);
        rem    = DIGIT_W'(conv_val_reg - quot10);
    end

    // Pick the character and detect the end of the phase
    always_comb
    begin
        case (phase_reg)
            PH_PRE:
            begin
                ch      = prefix_char(idx_reg);
                ph_last = (idx_reg == prefix_last_idx(ctl_reg.pre));
            end
            PH_HELD:
            begin
                ch      = CH_ZERO + {3'b000, held_reg[idx_reg[HIDX_W-1:0]]};
                ph_last = ((CMP_W'(idx_reg) + CMP_W'(1)) == CMP_W'(n_reg));
            end
            PH_TPRE:
            begin
                ch      = (idx_reg == '0) ? CH_AMP : CH_HASH;
                ph_last = (idx_reg == IDX_W'(1));
            end
            PH_DEC:
            begin
                ch      = CH_ZERO + {3'b000, dec_stack_reg[0]};
                ph_last = (dec_cnt_reg == DCNT_W'(1));
            end
            PH_RAW:
            begin
                ch      = ctl_reg.code_point[CH_W-1:0];
                ph_last = 1'b1;
            end
            default:
            begin
                ch      = CH_SEMI;
                ph_last = 1'b1;
            end
        endcase

        nxt        = find_phase(mask_reg, 3'(phase_reg) + 3'd1);
        new_mask   = mask_of(job_ctl.pre, job_ctl.tail, job_n != '0);
        first      = find_phase(new_mask, 3'd0);
        job_end    = ph_last && !nxt[3];
        char_ok    = cur_valid_reg && !((phase_reg == PH_DEC) && conv_busy_reg);
        out_free   = !out_valid_reg || chars.ready;
        emit       = char_ok && out_free;
        load       = q_valid && (!cur_valid_reg || (emit && job_end));
        conv_start = load && (job_ctl.tail == TAIL_NUM);
        conv_pop   = emit && (phase_reg == PH_DEC);
    end

    assign pop               = load;
    assign chars.valid       = out_valid_reg;
    assign chars.out_char    = out_char_reg;
    assign chars.last_of_run = out_lor_reg;
    assign chars.end_of_text = out_eot_reg;

    // Sequence phases, converter control and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            mask_reg      <= '0;
            phase_reg     <= PH_PRE;
            idx_reg       <= '0;
            conv_busy_reg <= 1'b0;
            dec_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_lor_reg   <= 1'b0;
            out_eot_reg   <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cur_valid_reg <= 1'b1;
                mask_reg      <= new_mask;
                phase_reg     <= phase_t'(first[2:0]);
                idx_reg       <= '0;
            end
            else if (emit)
            begin
                if (ph_last)
                begin
                    if (nxt[3])
                    begin
                        phase_reg <= phase_t'(nxt[2:0]);
                        idx_reg   <= '0;
                    end
                    else
                    begin
                        cur_valid_reg <= 1'b0;
                    end
                end
                else
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end

            if (conv_start)
            begin
                conv_busy_reg <= 1'b1;
                dec_cnt_reg   <= '0;
            end
            else if (conv_busy_reg)
            begin
                conv_busy_reg <= (quot != '0);
                dec_cnt_reg   <= dec_cnt_reg + DCNT_W'(1);
            end
            else if (conv_pop)
            begin
                dec_cnt_reg <= dec_cnt_reg - DCNT_W'(1);
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
                out_char_reg  <= ch;
                out_lor_reg   <= job_end;
                out_eot_reg   <= job_end && ctl_reg.last;
            end
            else if (chars.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold job payload and converter digits
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg <= job_ctl;
            n_reg   <= job_n;
            for (int i = 0; i < MAX_ENTITY_DIGITS; i++)
            begin
                held_reg[i] <= job_held[i*DIGIT_W +: DIGIT_W];
            end
        end

        if (conv_start)
        begin
            conv_val_reg <= job_ctl.code_point;
        end
        else if (conv_busy_reg)
        begin
            conv_val_reg     <= quot;
            dec_stack_reg[0] <= rem;
            for (int i = 1; i < DEC_DIGITS; i++)
            begin
                dec_stack_reg[i] <= dec_stack_reg[i-1];
            end
        end
        else if (conv_pop)
        begin
            for (int i = 0; i < DEC_DIGITS - 1; i++)
            begin
                dec_stack_reg[i] <= dec_stack_reg[i+1];
            end
        end
    end

endmodule

// ===== src/xml_entity_escaper.sv =====
// The job queue, the back end's current-job registers and the output register lie between
// an accepted word and its first character. One word per cycle in while the job queue is
// not full, one character per cycle out while the output is ready; the back end takes the
// next job only after the last character of the current one, and decimal digits wait on the divide-by-ten loop.
// Reset clears entity state, the job queue and the output register; no clearing pass.
module xml_entity_escaper import xee_pkg::*; #(
    parameter int MAX_ENTITY_DIGITS = 4,
    parameter int QUEUE_DEPTH       = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    xee_in_if.sink    points,
    xee_out_if.source chars
);

    localparam int CNT_W  = $clog2(MAX_ENTITY_DIGITS + 1);
    localparam int HELD_W = MAX_ENTITY_DIGITS * DIGIT_W;
    localparam int CTL_W  = $bits(job_ctl_t);
    localparam int JOB_W  = HELD_W + CNT_W + CTL_W;

    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              pop;
    job_ctl_t          f_ctl, b_ctl;
    logic [CNT_W-1:0]  f_n, b_n;
    logic [HELD_W-1:0] f_held, b_held;
    logic [JOB_W-1:0]  q_in, q_out;

    xee_front #(
        .MAX_ENTITY_DIGITS (MAX_ENTITY_DIGITS),
        .CNT_W             (CNT_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .points   (points),
        .q_full   (q_full),
        .push     (push),
        .job_ctl  (f_ctl),
        .job_n    (f_n),
        .job_held (f_held)
    );

    // Pack and unpack queue entries
    assign q_in = {f_held, f_n, f_ctl};
    assign b_ctl  = job_ctl_t'(q_out[CTL_W-1:0]);
    assign b_n    = q_out[CTL_W +: CNT_W];
    assign b_held = q_out[CTL_W + CNT_W +: HELD_W];

    xee_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (q_out),
        .not_empty (q_valid)
    );

    xee_back #(
        .MAX_ENTITY_DIGITS (MAX_ENTITY_DIGITS),
        .CNT_W             (CNT_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .pop      (pop),
        .job_ctl  (b_ctl),
        .job_n    (b_n),
        .job_held (b_held),
        .chars    (chars)
    );

endmodule

// ===== src/xee_checker.sv =====
// Port-level assertions for the entity escaper, bound to the top level.
module xee_checker import xee_pkg::*; (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            in_last,
    input logic            out_valid,
    input logic            out_ready,
    input logic [CH_W-1:0] out_char,
    input logic            out_lor,
    input logic            out_eot
);

    logic       in_fire;
    logic       out_fire;
    logic [3:0] pend_reg;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // Count texts whose end has been taken in but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {3'b000, in_fire && in_last}
                                 - {3'b000, out_fire && out_eot};
        end
    end

    // Stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) &&
                                    $stable(out_lor) && $stable(out_eot))
        else $error("output word changed while stalled");

    // End of text closes a run
    a_eot_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_eot |-> out_lor)
        else $error("end of text without end of run");

    // End of text only after a final input word was taken
    a_eot_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && out_eot |-> pend_reg != '0)
        else $error("end of text with no pending final word");

endmodule

bind xml_entity_escaper xee_checker u_xee_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (points.valid),
    .in_ready  (points.ready),
    .in_last   (points.is_last),
    .out_valid (chars.valid),
    .out_ready (chars.ready),
    .out_char  (chars.out_char),
    .out_lor   (chars.last_of_run),
    .out_eot   (chars.end_of_text)
);
